// ----- sv/srp_pkg.sv -----
// ----------------------------------------------------------------------------
// Sample rate profiler package
// Shared widths, request codes and timing constants of the profiler.
// ----------------------------------------------------------------------------
package srp_pkg;

	localparam int unsigned REQ_W      = 2;
	localparam int unsigned SAMPLES_W  = 16;
	localparam int unsigned SECONDS_W  = 32;
	localparam int unsigned MICROS_W   = 20;
	localparam int unsigned INTERVAL_W = 16;
	localparam int unsigned TOTAL_W    = 32;
	localparam int unsigned RATE_W     = 32;
	localparam int unsigned DUSEC_W    = 21;
	localparam int unsigned QUS_W      = 7;
	localparam int unsigned WIDE_W     = 39;
	localparam int unsigned S_TDATA_W  = 72;
	localparam int unsigned M_TDATA_W  = 64;

	localparam logic [REQ_W-1:0] REQ_VECTOR     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ACTIVATE   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DEACTIVATE = 2'd2;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET       = 16'd10000;
	localparam logic [MICROS_W-1:0]   MICROS_MAX           = 20'd999999;
	localparam logic [DUSEC_W-1:0]    MICROS_PER_SECOND    = 21'd1000000;
	localparam logic [DUSEC_W-1:0]    MICROS_HUND_TOP      = 21'd640000;
	localparam logic [WIDE_W-1:0]     HUNDREDTHS_PER_SEC   = 39'd100;
	localparam logic [5:0]            DIV_STEPS_LAST       = 6'd38;
	localparam logic [2:0]            QUS_STEPS_LAST       = 3'd6;

endpackage

// ----- sv/sample_rate_profiler_top.sv -----
// ----------------------------------------------------------------------------
// Sample rate profiler
// Counts samples over an interval of vectors and reports the total and the
// rate in samples per second, worked out by a bit-serial divider.
// ----------------------------------------------------------------------------
// Requests that do not close an interval are taken at one request a cycle. A
// request that closes an interval stalls the input through a 7-step
// microsecond divider, scaling in the multiply and hundredths states, a 39-step
// restoring divider and the load of the output register; with zero elapsed time
// the divider is skipped, and an unread report lengthens the stall.
// Reset is asynchronous and clears the control state; the interval resets to 10000.
module sample_rate_profiler_top
	import srp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [INTERVAL_W-1:0]  cfg_wr_data,    // interval_vectors
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // vector_samples, now_seconds, now_micros
	input  logic [REQ_W-1:0]       s_axis_tuser,   // req_type
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [M_TDATA_W-1:0]   m_axis_tdata,   // interval_samples, samples_per_second
	output logic                   m_axis_tuser    // zero_elapsed
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_QUS  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_HUND = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]            state_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic                  running_q;
	logic                  first_seen_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [INTERVAL_W-1:0] count_q;
	logic [SECONDS_W-1:0]  mark_s_q;
	logic [MICROS_W-1:0]   mark_us_q;

	logic [TOTAL_W-1:0]    rep_total_q;
	logic [SECONDS_W-1:0]  dsec_q;
	logic                  borrow_q;
	logic [DUSEC_W-1:0]    dusec_q;
	logic [DUSEC_W-1:0]    dv_q;
	logic [QUS_W-1:0]      qus_q;
	logic [2:0]            qstep_q;
	logic [WIDE_W-1:0]     hmul_q;
	logic [WIDE_W-1:0]     num_q;
	logic [WIDE_W-1:0]     den_q;
	logic [WIDE_W-1:0]     rem_q;
	logic [5:0]            dstep_q;
	logic                  zero_q;
	logic                  m_valid_q;
	logic [M_TDATA_W-1:0]  m_data_q;
	logic                  m_user_q;

	logic [SAMPLES_W-1:0]  in_samples;
	logic [SECONDS_W-1:0]  in_seconds;
	logic [MICROS_W-1:0]   in_micros_raw;
	logic [MICROS_W-1:0]   in_micros;
	logic                  accept;
	logic [TOTAL_W:0]      sum_wide;
	logic [TOTAL_W-1:0]    total_sat;
	logic [INTERVAL_W-1:0] count_next;
	logic                  borrow;
	logic [DUSEC_W-1:0]    dusec;
	logic [WIDE_W:0]       hund;
	logic [WIDE_W:0]       rem_sh;
	logic                  div_ge;
	logic                  out_load;
	logic [RATE_W-1:0]     rate;

	assign in_samples    = s_axis_tdata[SAMPLES_W-1:0];
	assign in_seconds    = s_axis_tdata[SAMPLES_W +: SECONDS_W];
	assign in_micros_raw = s_axis_tdata[SAMPLES_W+SECONDS_W +: MICROS_W];
	assign in_micros     = (in_micros_raw > MICROS_MAX) ? MICROS_MAX : in_micros_raw;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign sum_wide   = {1'b0, total_q} + {{(TOTAL_W+1-SAMPLES_W){1'b0}}, in_samples};
	assign total_sat  = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];
	assign count_next = count_q + 16'd1;
	assign borrow     = (in_micros <= mark_us_q);
	assign dusec      = {1'b0, in_micros} + (borrow ? MICROS_PER_SECOND : '0)
	                    - {1'b0, mark_us_q};

	assign hund = {1'b0, hmul_q} + {{(WIDE_W+1-QUS_W){1'b0}}, qus_q}
	              - (borrow_q ? {1'b0, HUNDREDTHS_PER_SEC} : '0);

	assign rem_sh = {rem_q, num_q[WIDE_W-1]};
	assign div_ge = (rem_sh >= {1'b0, den_q});

	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
	assign rate     = zero_q ? '0 :
	                  ((|num_q[WIDE_W-1:RATE_W]) ? {RATE_W{1'b1}} : num_q[RATE_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_wr_en) begin
			interval_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			running_q    <= 1'b0;
			first_seen_q <= 1'b0;
			total_q      <= '0;
			count_q      <= '0;
			mark_s_q     <= '0;
			mark_us_q    <= '0;
			qstep_q      <= '0;
			dstep_q      <= '0;
			zero_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_axis_tuser)
							REQ_ACTIVATE: begin
								running_q <= 1'b1;
							end
							REQ_DEACTIVATE: begin
								running_q    <= 1'b0;
								first_seen_q <= 1'b0;
							end
							REQ_VECTOR: begin
								if (running_q && !first_seen_q) begin
									first_seen_q <= 1'b1;
									mark_s_q     <= in_seconds;
									mark_us_q    <= in_micros;
									total_q      <= '0;
								end else if (running_q) begin
									if (count_next == interval_q) begin
										total_q   <= '0;
										count_q   <= '0;
										mark_s_q  <= in_seconds;
										mark_us_q <= in_micros;
										qstep_q   <= QUS_STEPS_LAST;
										state_q   <= ST_QUS;
									end else begin
										total_q <= total_sat;
										count_q <= count_next;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_QUS: begin
					qstep_q <= qstep_q - 3'd1;
					if (qstep_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_HUND;
				end
				ST_HUND: begin
					zero_q  <= hund[WIDE_W] || (hund == '0);
					dstep_q <= DIV_STEPS_LAST;
					state_q <= (hund[WIDE_W] || (hund == '0)) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					dstep_q <= dstep_q - 6'd1;
					if (dstep_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rep_total_q <= total_sat;
				dsec_q      <= in_seconds - mark_s_q;
				borrow_q    <= borrow;
				dusec_q     <= dusec;
				dv_q        <= MICROS_HUND_TOP;
				qus_q       <= '0;
			end
			ST_QUS: begin
				if (dusec_q >= dv_q) begin
					dusec_q <= dusec_q - dv_q;
					qus_q   <= {qus_q[QUS_W-2:0], 1'b1};
				end else begin
					qus_q   <= {qus_q[QUS_W-2:0], 1'b0};
				end
				dv_q <= {1'b0, dv_q[DUSEC_W-1:1]};
			end
			ST_MUL: begin
				hmul_q <= {{(WIDE_W-SECONDS_W){1'b0}}, dsec_q} * HUNDREDTHS_PER_SEC;
				num_q  <= {{(WIDE_W-TOTAL_W){1'b0}}, rep_total_q} * HUNDREDTHS_PER_SEC;
			end
			ST_HUND: begin
				den_q <= hund[WIDE_W-1:0];
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= div_ge ? WIDE_W'(rem_sh - {1'b0, den_q}) : rem_sh[WIDE_W-1:0];
				num_q <= {num_q[WIDE_W-2:0], div_ge};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {rate, rep_total_q};
			m_user_q <= zero_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample rate profiler testbench
// A short table of hand-picked requests is followed by random profiling runs
// under several interval settings and one interval whose rate saturates. Every
// accepted request is fed to a local model of the profiler, and each report is
// compared field by field with the row's typed report or else the model's report.
// ----------------------------------------------------------------------------
module tb_top;
	import srp_pkg::*;

	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 60;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned PHASE_ITEMS   = 115;
	localparam int unsigned WIDE_ITEMS    = 60;
	localparam logic [INTERVAL_W-1:0] SAT_VECTORS = 16'd700;

	typedef struct {
		logic [REQ_W-1:0]     req;
		logic [SAMPLES_W-1:0] samples;
		logic [SECONDS_W-1:0] seconds;
		logic [MICROS_W-1:0]  micros;
	} request_t;

	typedef struct {
		logic [TOTAL_W-1:0] total;
		logic [RATE_W-1:0]  rate;
		logic               zero;
	} report_t;

	typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		request_t  rq;
		bit        typed;
		report_t   want;
	} row_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_wr_en     = 1'b0;
	logic [INTERVAL_W-1:0] cfg_wr_data   = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [REQ_W-1:0]      s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  m_axis_tuser;

	// Model state of the profiler.
	bit                    prof_on   = 1'b0;
	bit                    armed     = 1'b0;
	logic [TOTAL_W-1:0]    acc_total = '0;
	logic [INTERVAL_W-1:0] vec_cnt   = '0;
	logic [INTERVAL_W-1:0] intv      = INTERVAL_RESET;
	logic [SECONDS_W-1:0]  mark_s    = '0;
	logic [MICROS_W-1:0]   mark_us   = '0;

	report_t         report_q[$];
	report_t         no_report;
	row_t            dir_rows[$];
	int unsigned     fail_count  = 0;
	int unsigned     idle_cycles = 0;
	int unsigned     sink_wait   = 0;
	bit              fast        = 1'b0;
	logic [SECONDS_W-1:0] tod_s  = '0;
	logic [MICROS_W-1:0]  tod_us = '0;

	sample_rate_profiler_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (fast)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Advances the model by one request; returns 1 when an interval closes.
	function automatic bit profile_step(input request_t rq, output report_t rep);
		logic [MICROS_W-1:0]  us;
		logic [SECONDS_W-1:0] dsec;
		logic [DUSEC_W-1:0]   dus;
		longint               hund;
		longint               dus_l;
		longint unsigned      wide;
		longint unsigned      hund_u;
		longint unsigned      q;
		bit                   brw;
		bit                   hit;
		hit = 1'b0;
		rep.total = '0;
		rep.rate = '0;
		rep.zero = 1'b0;
		us = (rq.micros > MICROS_MAX) ? MICROS_MAX : rq.micros;
		case (rq.req)
			REQ_ACTIVATE: begin
				prof_on = 1'b1;
			end
			REQ_DEACTIVATE: begin
				prof_on = 1'b0;
				armed = 1'b0;
			end
			REQ_VECTOR: begin
				if (prof_on && !armed) begin
					armed = 1'b1;
					mark_s = rq.seconds;
					mark_us = us;
					acc_total = '0;
				end else if (prof_on) begin
					wide = acc_total;
					wide = wide + rq.samples;
					acc_total = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(wide);
					vec_cnt = vec_cnt + 16'd1;
					if (vec_cnt == intv) begin
						hit = 1'b1;
						dsec = rq.seconds - mark_s;
						brw = (us <= mark_us);
						if (brw)
							dus = MICROS_PER_SECOND + us - mark_us;
						else
							dus = us - mark_us;
						dus_l = dus;
						hund = dsec;
						hund = hund * 100 - (brw ? 100 : 0) + dus_l / 10000;
						rep.total = acc_total;
						if (hund <= 0) begin
							rep.zero = 1'b1;
						end else begin
							wide = acc_total;
							hund_u = hund;
							q = (wide * 100) / hund_u;
							rep.rate = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(q);
						end
						vec_cnt = '0;
						mark_s = rq.seconds;
						mark_us = us;
						acc_total = '0;
					end
				end
			end
			default: begin
			end
		endcase
		return hit;
	endfunction

	function automatic request_t random_request();
		int unsigned r;
		int unsigned k;
		int unsigned adv;
		request_t    rq;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 9);
		rq.req = REQ_VECTOR;
		if (k == 0)
			rq.samples = '0;
		else if (k == 1)
			rq.samples = '1;
		else if (k == 2)
			rq.samples = 16'($urandom_range(0, 15));
		else
			rq.samples = 16'($urandom_range(0, 65535));
		if (!prof_on && r < 50) begin
			rq.req = REQ_ACTIVATE;
		end else if (r < 4) begin
			rq.req = REQ_DEACTIVATE;
		end else if (r < 7) begin
			rq.req = REQ_SPARE;
			tod_s = tod_s;
		end else if (r < 9) begin
			rq.req = REQ_ACTIVATE;
		end else if (r < 13) begin
			tod_s = $urandom();
			rq.micros = 20'($urandom_range(0, 20'hFFFFF));
			tod_us = (rq.micros > MICROS_MAX) ? MICROS_MAX : rq.micros;
		end else if (r < 16) begin
			rq.micros = 20'($urandom_range(0, tod_us));
		end else begin
			adv = (r < 26) ? $urandom_range(0, 20000) : $urandom_range(0, 300000);
			adv = adv + tod_us;
			if (adv >= 1000000) begin
				adv = adv - 1000000;
				tod_s = tod_s + 32'd1;
			end
			tod_us = 20'(adv);
		end
		rq.seconds = tod_s;
		if (r >= 16 || r < 9)
			rq.micros = tod_us;
		if (rq.req == REQ_SPARE) begin
			rq.seconds = $urandom();
			rq.micros = 20'($urandom_range(0, 20'hFFFFF));
		end
		return rq;
	endfunction

	task automatic add_row(input row_kind_t kind, input logic [REQ_W-1:0] req,
			input logic [SAMPLES_W-1:0] n, input logic [SECONDS_W-1:0] s,
			input logic [MICROS_W-1:0] us, input bit typed = 1'b0,
			input logic [TOTAL_W-1:0] tot = '0, input logic [RATE_W-1:0] rt = '0,
			input logic z = 1'b0);
		row_t row;
		row.kind = kind;
		row.rq.req = req;
		row.rq.samples = n;
		row.rq.seconds = s;
		row.rq.micros = us;
		row.typed = typed;
		row.want.total = tot;
		row.want.rate = rt;
		row.want.zero = z;
		dir_rows.push_back(row);
	endtask

	task automatic send_item(input request_t rq, input bit typed, input report_t want);
		int unsigned gap;
		report_t     rep;
		gap = pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(S_TDATA_W - SAMPLES_W - SECONDS_W - MICROS_W){1'b0}},
			rq.micros, rq.seconds, rq.samples};
		s_axis_tuser <= rq.req;
		do @(posedge clk); while (!s_axis_tready);
		if (profile_step(rq, rep) && !typed)
			report_q.push_back(rep);
		if (typed)
			report_q.push_back(want);
	endtask

	// The interval is only rewritten once every report has drained.
	task automatic set_interval(input logic [INTERVAL_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		intv = v;
	endtask

	always @(posedge clk) begin : sink
		report_t got;
		report_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.total = m_axis_tdata[31:0];
			got.rate = m_axis_tdata[63:32];
			got.zero = m_axis_tuser;
			if (report_q.size() == 0) begin
				$error("unexpected report: interval_samples %0d, samples_per_second %0d",
					got.total, got.rate);
				fail_count++;
			end else begin
				want = report_q.pop_front();
				if (got.total !== want.total) begin
					$error("interval_samples: expected %0d, actual %0d", want.total, got.total);
					fail_count++;
				end
				if (got.rate !== want.rate) begin
					$error("samples_per_second: expected %0d, actual %0d",
						want.rate, got.rate);
					fail_count++;
				end
				if (got.zero !== want.zero) begin
					$error("zero_elapsed: expected %0d, actual %0d", want.zero, got.zero);
					fail_count++;
				end
			end
		end
		if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			m_axis_tready <= 1'b0;
		end else if (!fast && $urandom_range(0, 4) == 0) begin
			sink_wait <= pick_gap();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned          phase_len;
		int unsigned          done;
		int unsigned          choice;
		int unsigned          plan[8];
		logic [SECONDS_W-1:0] long_s;
		request_t             rq;
		plan = '{1, 2, 7, 65535, 3, 20, 1, 5};
		no_report.total = '0;
		no_report.rate = '0;
		no_report.zero = 1'b0;

		add_row(ROW_REQ, REQ_SPARE,      16'd0,     32'd0,         20'd0);
		add_row(ROW_REQ, REQ_VECTOR,     16'd4,     32'd1,         20'd0);
		add_row(ROW_REQ, REQ_ACTIVATE,   16'd0,     32'd0,         20'd0);
		add_row(ROW_REQ, REQ_ACTIVATE,   16'd0,     32'd0,         20'd0);
		add_row(ROW_CFG, REQ_VECTOR,     16'd1,     32'd0,         20'd0);
		add_row(ROW_REQ, REQ_VECTOR,     16'd5,     32'd100,       20'd0);
		add_row(ROW_REQ, REQ_VECTOR,     16'hFFFF,  32'd101,       20'd0,
			1'b1, 32'd65535, 32'd65535, 1'b0);
		add_row(ROW_REQ, REQ_VECTOR,     16'd0,     32'd101,       20'd0,
			1'b1, 32'd0, 32'd0, 1'b1);
		add_row(ROW_REQ, REQ_VECTOR,     16'd7,     32'd101,       20'd999999);
		add_row(ROW_REQ, REQ_VECTOR,     16'd3,     32'd101,       20'd500000,
			1'b1, 32'd3, 32'd0, 1'b1);
		add_row(ROW_REQ, REQ_VECTOR,     16'd10,    32'd102,       20'hFFFFF);
		add_row(ROW_REQ, REQ_VECTOR,     16'hFFFF,  32'hFFFF_FFFF, 20'd0);
		add_row(ROW_REQ, REQ_VECTOR,     16'd0,     32'd0,         20'd999999);
		add_row(ROW_REQ, REQ_SPARE,      16'hFFFF,  32'hFFFF_FFFF, 20'hFFFFF);
		add_row(ROW_REQ, REQ_DEACTIVATE, 16'd0,     32'd0,         20'd0);
		add_row(ROW_REQ, REQ_VECTOR,     16'd9,     32'd5,         20'd0);
		add_row(ROW_REQ, REQ_ACTIVATE,   16'd0,     32'd0,         20'd0);
		add_row(ROW_REQ, REQ_VECTOR,     16'd100,   32'd10,        20'd0);
		add_row(ROW_REQ, REQ_VECTOR,     16'd200,   32'd10,        20'd10000,
			1'b1, 32'd200, 32'd20000, 1'b0);
		add_row(ROW_CFG, REQ_VECTOR,     16'd3,     32'd0,         20'd0);
		add_row(ROW_REQ, REQ_VECTOR,     16'd1,     32'd11,        20'd0);
		add_row(ROW_REQ, REQ_DEACTIVATE, 16'd0,     32'd0,         20'd0);
		add_row(ROW_REQ, REQ_ACTIVATE,   16'd0,     32'd0,         20'd0);
		add_row(ROW_REQ, REQ_VECTOR,     16'd50,    32'd20,        20'd0);
		add_row(ROW_REQ, REQ_VECTOR,     16'd60,    32'd21,        20'd0);
		add_row(ROW_REQ, REQ_VECTOR,     16'd40,    32'd22,        20'd0,
			1'b1, 32'd100, 32'd50, 1'b0);

		tod_s = $urandom();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				set_interval(dir_rows[i].rq.samples);
			else
				send_item(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
		end

		// The interval must stay above the running vector count to avoid a wrap.
		foreach (plan[p]) begin
			choice = plan[p];
			if (choice <= vec_cnt)
				choice = vec_cnt + choice;
			if (choice > 65535)
				choice = 65535;
			set_interval(16'(choice));
			fast = ($urandom_range(0, 3) == 0);
			phase_len = (choice == 65535) ? WIDE_ITEMS : PHASE_ITEMS;
			done = 0;
			while (done < phase_len) begin
				if ($urandom_range(0, 149) == 0) begin
					s_axis_tvalid <= 1'b0;
					@(posedge clk);
					while (report_q.size() != 0) @(posedge clk);
				end
				rq = random_request();
				if (rq.req != REQ_SPARE && (rq.req != REQ_VECTOR || prof_on))
					done++;
				send_item(rq, 1'b0, no_report);
			end
		end

		// One interval of full vectors that closes a hundredth of a second after
		// its mark, so the rate saturates.
		set_interval(vec_cnt + SAT_VECTORS);
		fast = 1'b1;
		long_s = $urandom();
		rq = '{REQ_DEACTIVATE, 16'hFFFF, long_s, 20'd0};
		send_item(rq, 1'b0, no_report);
		rq.req = REQ_ACTIVATE;
		send_item(rq, 1'b0, no_report);
		rq.req = REQ_VECTOR;
		send_item(rq, 1'b0, no_report);
		while (vec_cnt + 16'd1 != intv)
			send_item(rq, 1'b0, no_report);
		rq.micros = 20'd10000;
		send_item(rq, 1'b0, no_report);
		fast = 1'b0;

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (report_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
